>>> hw/rtl/cst_pkg.sv
// Shared types and constants for the counting semaphore table.
// Holds the word formats of both channels, the operation and status codes,
// and the controller-to-datapath command struct. Depends on nothing.
package cst_pkg;

    localparam int NUM_SEMAPHORES = 64;
    localparam int IDX_W          = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int GRP_SIZE       = 8;
    localparam int LOW_W          = (GRP_SIZE > 1) ? $clog2(GRP_SIZE) : 1;
    localparam int NUM_GROUPS     = (NUM_SEMAPHORES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GIDX_W         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int CNT_W          = 16;
    localparam int HANDLE_W       = 6;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_WAIT   = 2'd2,
        KIND_SIGNAL = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERR   = 2'd1,
        ST_BLOCK = 2'd2
    } t_status;

    typedef struct packed {
        t_kind                   kind;
        logic signed [CNT_W-1:0] sem_id;
        logic signed [CNT_W-1:0] initial_count;
    } t_in_word;

    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   handle_out;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

endpackage

>>> hw/rtl/cst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the semaphore count storage. Depends on nothing.
module cst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/cst_ctrl.sv
// Sequencing controller for the counting semaphore table.
// Accepts one word, lets the datapath execute it, and owns the output valid.
// Depends on cst_pkg.
module cst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cst_pkg::t_cmd o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   commit;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cmd.capture  = accept;
    assign o_cmd.commit   = commit;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("Accepted word did not move the controller to execute.");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_out_valid && r_state == S_IDLE))
        else $error("Committed word did not produce a pending result.");

    a_capture_commit_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.commit))
        else $error("Capture and commit were issued in the same cycle.");

endmodule

>>> hw/rtl/cst_datapath.sv
// Datapath of the counting semaphore table: valid bits, written bits, the
// count RAM, the free-entry search tree and the result register.
// Depends on cst_pkg and cst_ram.
module cst_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cst_pkg::t_cmd      i_cmd,
    input  cst_pkg::t_in_word  i_in_word,
    output cst_pkg::t_out_word o_out_word
);

    localparam int N      = cst_pkg::NUM_SEMAPHORES;
    localparam int IDX_W  = cst_pkg::IDX_W;
    localparam int GRP    = cst_pkg::GRP_SIZE;
    localparam int NGRP   = cst_pkg::NUM_GROUPS;
    localparam int LOW_W  = cst_pkg::LOW_W;
    localparam int GIDX_W = cst_pkg::GIDX_W;
    localparam int CNT_W  = cst_pkg::CNT_W;

    cst_pkg::t_in_word  r_req;
    cst_pkg::t_out_word r_out_word;
    cst_pkg::t_out_word n_out_word;

    logic [N-1:0]          r_valid;
    logic [N-1:0]          r_written;
    logic [NGRP-1:0]       r_grp_free;
    logic [NGRP-1:0]       n_grp_free;
    logic [LOW_W-1:0]      r_grp_low [NGRP];
    logic [LOW_W-1:0]      n_grp_low [NGRP];
    logic [NGRP*GRP-1:0]   pad_valid;

    logic [IDX_W-1:0]        req_slot;
    logic                    in_range;
    logic                    ent_valid;
    logic [CNT_W-1:0]        rd_data;
    logic signed [CNT_W-1:0] ent_count;
    logic                    found;
    logic [GIDX_W-1:0]       found_grp;
    logic [IDX_W-1:0]        free_idx;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [CNT_W-1:0] wr_data;
    logic                    set_valid;
    logic                    clr_valid;

    always_comb begin
        pad_valid        = '1;
        pad_valid[N-1:0] = r_valid;
        for (int g = 0; g < NGRP; g++) begin
            n_grp_free[g] = ~&pad_valid[g*GRP +: GRP];
            n_grp_low[g]  = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (!pad_valid[g*GRP + j]) begin
                    n_grp_low[g] = LOW_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_free <= n_grp_free;
        for (int g = 0; g < NGRP; g++) begin
            r_grp_low[g] <= n_grp_low[g];
        end
    end

    always_comb begin
        found     = 1'b0;
        found_grp = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                found     = 1'b1;
                found_grp = GIDX_W'(g);
            end
        end
    end

    assign free_idx  = IDX_W'({found_grp, r_grp_low[found_grp]});
    assign req_slot  = r_req.sem_id[IDX_W-1:0];
    assign in_range  = !r_req.sem_id[CNT_W-1] &&
                       (r_req.sem_id[CNT_W-2:0] < (CNT_W-1)'(N));
    assign ent_valid = r_valid[req_slot];
    assign ent_count = r_written[req_slot] ? $signed(rd_data) : '0;

    always_comb begin
        n_out_word.status     = cst_pkg::ST_ERR;
        n_out_word.handle_out = '0;
        wr_en                 = 1'b0;
        wr_addr               = req_slot;
        wr_data               = ent_count;
        set_valid             = 1'b0;
        clr_valid             = 1'b0;
        unique case (r_req.kind)
            cst_pkg::KIND_CREATE: begin
                if (found) begin
                    n_out_word.status     = cst_pkg::ST_OK;
                    n_out_word.handle_out = cst_pkg::HANDLE_W'(free_idx);
                    wr_en                 = 1'b1;
                    wr_addr               = free_idx;
                    wr_data               = r_req.initial_count;
                    set_valid             = 1'b1;
                end
            end
            cst_pkg::KIND_DELETE: begin
                if (in_range && ent_valid) begin
                    n_out_word.status = cst_pkg::ST_OK;
                    clr_valid         = 1'b1;
                end
            end
            cst_pkg::KIND_WAIT: begin
                if (in_range) begin
                    if (ent_valid && ent_count <= 0) begin
                        n_out_word.status = cst_pkg::ST_BLOCK;
                    end else begin
                        n_out_word.status = cst_pkg::ST_OK;
                        wr_en             = 1'b1;
                        if (ent_count != cst_pkg::CNT_MIN) begin
                            wr_data = ent_count - 16'sd1;
                        end
                    end
                end
            end
            cst_pkg::KIND_SIGNAL: begin
                if (in_range && ent_valid) begin
                    n_out_word.status = cst_pkg::ST_OK;
                    wr_en             = 1'b1;
                    if (ent_count != cst_pkg::CNT_MAX) begin
                        wr_data = ent_count + 16'sd1;
                    end
                end
            end
            default: begin
                n_out_word.status = cst_pkg::ST_ERR;
            end
        endcase
    end

    cst_ram #(
        .WIDTH (CNT_W),
        .DEPTH (N)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (i_in_word.sem_id[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_word;
        end
        if (i_cmd.commit) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_written <= '0;
        end else if (i_cmd.commit) begin
            if (wr_en) begin
                r_written[wr_addr] <= 1'b1;
            end
            if (set_valid) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (clr_valid) begin
                r_valid[req_slot] <= 1'b0;
            end
        end
    end

    assign o_out_word = r_out_word;

    a_create_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && set_valid) |=> r_valid[$past(free_idx)])
        else $error("Successful create left its entry free.");

    a_delete_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && clr_valid) |=> !r_valid[$past(req_slot)])
        else $error("Successful delete left its entry valid.");

    a_block_keeps_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_out_word.status == cst_pkg::ST_BLOCK) |=>
        (r_valid == $past(r_valid) && r_written == $past(r_written)))
        else $error("A blocked wait changed the table.");

endmodule

>>> hw/rtl/counting_semaphore_table.sv
// Top level of the counting semaphore table.
// Joins the sequencing controller and the datapath. Depends on cst_pkg,
// cst_ctrl and cst_datapath.
//
// Usage: each input word carries one operation (create, delete, wait or
// signal), a handle and an initial count, and gives exactly one output word
// with a status and, for a successful create, the claimed handle.
// Both channels use valid and ready; a word moves when both are high.
// The block takes one word, reads the addressed count from the count RAM in
// the accept cycle, and in the execute state computes the result, writes
// the updated count and valid bit back, and loads the output register.
// The output valid is registered and rises once the commit has loaded the
// output register; a new word is only accepted in the idle state, as each
// word reads, modifies and writes back one count RAM entry. A create finds
// the lowest free entry through a registered two-level search over the
// valid bits.
// When the receiver stalls, the finished word waits in the output register
// while the next word is still accepted; that word then holds in the execute
// state until the output register is taken.
// Reset clears all valid bits and marks every count as zero at once; the
// block is ready in the first cycle after reset.
module counting_semaphore_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cst_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cst_pkg::t_out_word o_out_word
);

    cst_pkg::t_cmd cmd;

    cst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    cst_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule
